// ===== src/mus_event_stream_parser_top_defines.svh =====
// Assertion macros for the music event stream parser.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef MUS_EVENT_STREAM_PARSER_TOP_DEFINES_SVH
`define MUS_EVENT_STREAM_PARSER_TOP_DEFINES_SVH

// Clocked property, disabled during reset
`define MUS_ESP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define MUS_ESP_ASSERT_IMP(lbl, ante, cons, msg) \
  `MUS_ESP_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication
`define MUS_ESP_ASSERT_NXT(lbl, ante, cons, msg) \
  `MUS_ESP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== src/mus_esp_pkg.sv =====
// Types and constants of the music event stream parser.
// No dependencies; used by the output interface and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mus_esp_pkg;

  localparam int unsigned DelayBitsDef = 28;
  localparam int unsigned DelayOutW    = 28;
  localparam int unsigned NumChannels  = 16;

  localparam logic [6:0] VolumeReset   = 7'h7F;
  localparam logic [3:0] PercChannel   = 4'd15;
  localparam logic [6:0] PercNoteLow   = 7'd35;
  localparam logic [6:0] PercNoteHigh  = 7'd81;
  localparam logic [6:0] PercPitch     = 7'd60;
  // note - 35 + 128
  localparam logic [7:0] PercInstrOfs  = 8'd93;
  localparam logic [6:0] CtrlInstrument = 7'd0;
  localparam logic [6:0] CtrlVolume     = 7'd3;

  // Header commands
  localparam logic [2:0] CmdNoteOff  = 3'd0;
  localparam logic [2:0] CmdNoteOn   = 3'd1;
  localparam logic [2:0] CmdPitch    = 3'd2;
  localparam logic [2:0] CmdSystem   = 3'd3;
  localparam logic [2:0] CmdCtrl     = 3'd4;
  localparam logic [2:0] CmdScoreEnd = 3'd6;

  typedef enum logic [2:0] {
    EV_NOTE_OFF  = 3'd0,
    EV_NOTE_ON   = 3'd1,
    EV_DELAY     = 3'd2,
    EV_SCORE_END = 3'd3,
    EV_ERROR     = 3'd4
  } event_kind_e;

  typedef enum logic [7:0] {
    PH_HEADER   = 8'b0000_0001,
    PH_OFF_NOTE = 8'b0000_0010,
    PH_ON_NOTE  = 8'b0000_0100,
    PH_ON_VOL   = 8'b0000_1000,
    PH_SKIP     = 8'b0001_0000,
    PH_CTRL_NUM = 8'b0010_0000,
    PH_CTRL_VAL = 8'b0100_0000,
    PH_DELAY    = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    event_kind_e          event_kind;
    logic [3:0]           channel;
    logic [6:0]           note;
    logic [6:0]           pitch;
    logic [7:0]           instrument_index;
    logic [6:0]           volume;
    logic [DelayOutW-1:0] delay_ticks;
  } result_t;

endpackage

`default_nettype wire

// ===== src/mus_esp_in_if.sv =====
// Input byte channel of the music event stream parser.
// Depends on nothing but the valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface mus_esp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== src/mus_esp_out_if.sv =====
// Result channel of the music event stream parser.
// Depends on mus_esp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mus_esp_out_if;
  import mus_esp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [2:0]           event_kind;
  logic [3:0]           channel;
  logic [6:0]           note;
  logic [6:0]           pitch;
  logic [7:0]           instrument_index;
  logic [6:0]           volume;
  logic [DelayOutW-1:0] delay_ticks;

  modport source (output valid, output event_kind, output channel, output note,
                  output pitch, output instrument_index, output volume,
                  output delay_ticks, input ready);
  modport sink   (input valid, input event_kind, input channel, input note,
                  input pitch, input instrument_index, input volume,
                  input delay_ticks, output ready);
endinterface

`default_nettype wire

// ===== src/mus_esp_cfg_if.sv =====
// Configuration write channel: initial channel volume.
// Depends on nothing but the valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface mus_esp_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] initial_volume;

  modport source (output valid, output initial_volume, input ready);
  modport sink   (input valid, input initial_volume, output ready);
endinterface

`default_nettype wire

// ===== src/mus_event_stream_parser_top.sv =====
// Latency: a result is valid in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle unless the single output register holds an untaken result.
// Byte parsing and the per-channel volume/instrument update happen in the same cycle.
// Reset: parser waits for a header, every channel volume 127, every instrument 0.
// Score end or an unknown command halts the parser until reset; bytes are then dropped.
// Top level of the music event stream parser; depends on mus_esp_pkg,
// the three channel interfaces and mus_event_stream_parser_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "mus_event_stream_parser_top_defines.svh"

module mus_event_stream_parser_top #(
  parameter int unsigned DELAY_BITS = mus_esp_pkg::DelayBitsDef
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  mus_esp_cfg_if.sink   cfg_i,
  mus_esp_in_if.sink    in_i,
  mus_esp_out_if.source out_o
);
  import mus_esp_pkg::*;

  localparam int unsigned WideW = DELAY_BITS + DelayOutW;

  // Parser state
  phase_e                phase_q, phase_d;
  logic [3:0]            chan_q, chan_d;
  logic                  grp_end_q, grp_end_d;
  logic [7:0]            second_q, second_d;
  logic [DELAY_BITS-1:0] delay_q, delay_d;
  logic                  halted_q, halted_d;
  logic [6:0]            vol_q [NumChannels];
  logic [7:0]            instr_q [NumChannels];

  // Channel table update of this byte
  logic       vol_we, instr_we;
  logic [6:0] vol_wdata;
  logic [7:0] instr_wdata;

  // Result register
  result_t res, out_q;
  logic    res_valid;
  logic    out_valid_q, out_valid_d;

  logic       in_fire;
  logic [6:0] low;
  logic [6:0] note_sel;
  logic [6:0] vol_cur;
  logic [7:0] instr_cur;
  logic       perc_skip;
  logic [DELAY_BITS-1:0] delay_next;
  logic [WideW-1:0]      delay_wide;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = out_o.ready || !out_valid_q;
  assign in_fire     = in_i.valid && in_i.ready;
  assign low         = in_i.data_byte[6:0];

  // Note of a pending note-on: the latched byte when a volume byte follows
  assign note_sel  = (phase_q == PH_ON_VOL) ? second_q[6:0] : low;
  assign perc_skip = (chan_q == PercChannel) &&
                     ((note_sel < PercNoteLow) || (note_sel > PercNoteHigh));
  assign vol_cur   = vol_q[chan_q];
  assign instr_cur = instr_q[chan_q];

  // Saturating shift-in of seven delay bits
  always_comb begin
    if (delay_q[DELAY_BITS-1 -: 7] != 7'd0) begin
      delay_next = '1;
    end else begin
      delay_next = {delay_q[DELAY_BITS-8:0], low};
    end
  end
  assign delay_wide = {{DelayOutW{1'b0}}, delay_next};

  // Parse one byte
  always_comb begin
    phase_d     = phase_q;
    chan_d      = chan_q;
    grp_end_d   = grp_end_q;
    second_d    = second_q;
    delay_d     = delay_q;
    halted_d    = halted_q;
    vol_we      = 1'b0;
    vol_wdata   = low;
    instr_we    = 1'b0;
    instr_wdata = {1'b0, low};
    res         = '0;
    res_valid   = 1'b0;

    if (!halted_q) begin
      case (phase_q)
        PH_HEADER: begin
          grp_end_d = in_i.data_byte[7];
          chan_d    = in_i.data_byte[3:0];
          case (in_i.data_byte[6:4])
            CmdNoteOff:          phase_d = PH_OFF_NOTE;
            CmdNoteOn:           phase_d = PH_ON_NOTE;
            CmdPitch, CmdSystem: phase_d = PH_SKIP;
            CmdCtrl:             phase_d = PH_CTRL_NUM;
            CmdScoreEnd: begin
              res.event_kind = EV_SCORE_END;
              res_valid      = 1'b1;
              halted_d       = 1'b1;
            end
            default: begin
              res.event_kind = EV_ERROR;
              res_valid      = 1'b1;
              halted_d       = 1'b1;
            end
          endcase
        end
        PH_OFF_NOTE: begin
          res.event_kind = EV_NOTE_OFF;
          res.channel    = chan_q;
          res.note       = low;
          res_valid      = 1'b1;
        end
        PH_ON_NOTE, PH_ON_VOL: begin
          if (phase_q == PH_ON_NOTE && in_i.data_byte[7]) begin
            second_d = in_i.data_byte;
            phase_d  = PH_ON_VOL;
          end else begin
            // Volume byte lands even for a dropped percussion note
            vol_we = (phase_q == PH_ON_VOL);
            if (!perc_skip) begin
              res.event_kind       = EV_NOTE_ON;
              res.channel          = chan_q;
              res.note             = note_sel;
              res.pitch            = note_sel;
              res.instrument_index = instr_cur;
              res.volume           = vol_we ? low : vol_cur;
              res_valid            = 1'b1;
              if (chan_q == PercChannel) begin
                instr_we             = 1'b1;
                instr_wdata          = {1'b0, note_sel} + PercInstrOfs;
                res.pitch            = PercPitch;
                res.instrument_index = instr_wdata;
              end
            end
          end
        end
        PH_CTRL_NUM: begin
          second_d = in_i.data_byte;
          phase_d  = PH_CTRL_VAL;
        end
        PH_CTRL_VAL: begin
          instr_we = (second_q[6:0] == CtrlInstrument);
          vol_we   = (second_q[6:0] == CtrlVolume);
        end
        PH_DELAY: begin
          delay_d = delay_next;
          if (!in_i.data_byte[7]) begin
            res.event_kind  = EV_DELAY;
            res.delay_ticks = delay_wide[DelayOutW-1:0];
            res_valid       = 1'b1;
            phase_d         = PH_HEADER;
          end
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase

      // Close an event body: read a delay after a flagged group end
      if (phase_q inside {PH_OFF_NOTE, PH_SKIP, PH_CTRL_VAL} ||
          phase_q == PH_ON_VOL ||
          (phase_q == PH_ON_NOTE && !in_i.data_byte[7])) begin
        if (grp_end_q) begin
          delay_d = '0;
          phase_d = PH_DELAY;
        end else begin
          phase_d = PH_HEADER;
        end
      end
    end
  end

  // Advance parser state on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      chan_q    <= '0;
      grp_end_q <= 1'b0;
      second_q  <= '0;
      delay_q   <= '0;
      halted_q  <= 1'b0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      chan_q    <= chan_d;
      grp_end_q <= grp_end_d;
      second_q  <= second_d;
      delay_q   <= delay_d;
      halted_q  <= halted_d;
    end
  end

  // Channel tables; a configuration write reloads every volume
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChannels; c++) begin
        vol_q[c]   <= VolumeReset;
        instr_q[c] <= '0;
      end
    end else if (cfg_i.valid) begin
      for (int c = 0; c < NumChannels; c++) begin
        vol_q[c] <= cfg_i.initial_volume;
      end
    end else if (in_fire) begin
      if (vol_we) begin
        vol_q[chan_q] <= vol_wdata;
      end
      if (instr_we) begin
        instr_q[chan_q] <= instr_wdata;
      end
    end
  end

  // Hold a result until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_i.ready) begin
      out_valid_d = in_fire && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.event_kind       = out_q.event_kind;
  assign out_o.channel          = out_q.channel;
  assign out_o.note             = out_q.note;
  assign out_o.pitch            = out_q.pitch;
  assign out_o.instrument_index = out_q.instrument_index;
  assign out_o.volume           = out_q.volume;
  assign out_o.delay_ticks      = out_q.delay_ticks;

  // Checks
  `MUS_ESP_ASSERT_NXT(a_halt_sticky, halted_q, halted_q, "parser left the halted state")
  `MUS_ESP_ASSERT_IMP(a_halt_phase, halted_q, phase_q == PH_HEADER,
                      "halted parser not at header phase")
  `MUS_ESP_ASSERT_IMP(a_stall_holds, !in_i.ready, out_valid_q,
                      "input stalled with no result pending")
  `MUS_ESP_ASSERT_IMP(a_perc_note,
                      out_valid_q && out_q.event_kind == EV_NOTE_ON &&
                      out_q.channel == PercChannel,
                      out_q.pitch == PercPitch && out_q.instrument_index >= 8'd128 &&
                      out_q.instrument_index <= 8'd174,
                      "percussion note-on with bad pitch or instrument")

endmodule

`default_nettype wire
